// ===== hdl/lisp_source_minifier_assert.svh =====
// Assertion macros for the Lisp source minifier.
`ifndef LISP_SOURCE_MINIFIER_ASSERT_SVH
`define LISP_SOURCE_MINIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define LSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lisp_source_minifier assertion failed");
`define LSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lisp_source_minifier assertion failed");
`else
`define LSM_ASSERT_IMP(label, ante, cons)
`define LSM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hdl/lsm_pkg.sv =====
// Package with character codes, decision context and the per-byte decision function.
package lsm_pkg;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // "(vec " with the first character in element zero.
  localparam logic [4:0][7:0] VEC_OPEN = {8'h20, 8'h63, 8'h65, 8'h76, 8'h28};

  typedef struct packed {
    logic [1:0] skip_count;
    logic       in_comment;
    logic       comment_is_block;
    logic       after_comma;
    logic       in_quote;
    logic       after_literal;
    logic [7:0] prev_emitted;
  } ctx_t;

  localparam ctx_t CTX_RESET = '0;

  typedef struct packed {
    ctx_t            st;
    logic [4:0][7:0] bytes;
    logic [2:0]      cnt;
  } dec_res_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_COMMA) || (b == CH_SPACE) || (b == CH_NL) || (b == CH_SEMI);
  endfunction

  // Decides one byte from itself and the next two bytes.
  function automatic dec_res_t decide(ctx_t ctx, logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2);
    dec_res_t   r;
    logic       go;
    logic [7:0] c;
    r       = '0;
    r.st    = ctx;
    go      = 1'b0;
    c       = (b0 == CH_NL) ? CH_SPACE : b0;
    if (ctx.skip_count != 2'd0) begin
      r.st.skip_count = ctx.skip_count - 2'd1;
    end else if (ctx.after_literal) begin
      r.st.after_literal = 1'b0;
      go = 1'b1;
    end else if (ctx.in_comment) begin
      if (!ctx.comment_is_block && b0 == CH_NL) begin
        r.st.in_comment = 1'b0;
      end
      if (ctx.comment_is_block && b0 == CH_STAR && b1 == CH_SLASH) begin
        r.st.in_comment = 1'b0;
        r.st.skip_count = 2'd1;
      end
    end else begin
      // Whitespace after a comma is dropped; anything else ends that run.
      r.st.after_comma = ctx.after_comma & is_ws(b0);
      if (!r.st.after_comma) begin
        if (ctx.in_quote) begin
          if (b0 == CH_DQUOTE) begin
            r.st.in_quote = 1'b0;
          end
          r.bytes[0] = b0;
          r.cnt = 3'd1;
        end else begin
          if (b0 == CH_DQUOTE) begin
            r.st.in_quote = 1'b1;
          end
          if (b0 == CH_BSLASH) begin
            r.bytes[0] = b0;
            r.bytes[1] = b1;
            if (b2 == CH_SPACE) begin
              r.bytes[2] = b2;
              r.cnt = 3'd3;
              r.st.skip_count = 2'd2;
            end else begin
              r.cnt = 3'd2;
              r.st.skip_count = 2'd1;
            end
            r.st.after_literal = 1'b1;
          end else begin
            go = 1'b1;
          end
        end
      end
    end
    if (go) begin
      if (b0 == CH_LBRACK) begin
        r.bytes = VEC_OPEN;
        r.cnt = 3'd5;
      end else if (b0 == CH_RBRACK) begin
        r.bytes[0] = CH_RPAREN;
        r.cnt = 3'd1;
      end else if (b0 == CH_SLASH && (b1 == CH_SLASH || b1 == CH_STAR)) begin
        r.st.in_comment = 1'b1;
        r.st.comment_is_block = (b1 == CH_STAR);
      end else begin
        if (is_ws(b0)) begin
          r.st.after_comma = (b0 == CH_COMMA);
        end
        if (!(is_ws(b0) && is_ws(ctx.prev_emitted))) begin
          r.st.prev_emitted = c;
          r.bytes[0] = c;
          r.cnt = 3'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/lisp_source_minifier.sv =====
// Top level of the streaming Lisp source minifier.
// A byte enters the burst register at the edge that accepts the beat completing its lookahead,
// and passes on to the output register when that register is free.
// Unless stalled, the input takes one beat per cycle and the output gives one byte per cycle;
// a beat that expands into several bytes holds the input until its last byte can leave the burst register.
// A final beat holds the input while the sequencer decides the bytes it leaves (up to three),
// longer while its bursts wait on the output, and until its last byte leaves the burst register.
// Reset: synchronous, clears the lookahead window, the context and all valid flags.
`include "lisp_source_minifier_assert.svh"
module lisp_source_minifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       stream_done
);
  import lsm_pkg::*;

  // Lookahead window and decision context.
  logic [1:0] pend;
  logic [7:0] win0;
  logic [7:0] win1;
  ctx_t       ctx;

  // Final-beat sequencer: decides the held bytes one per cycle while the burst register can take them.
  logic             tail_active;
  logic [2:0][7:0]  t_buf;
  logic [1:0]       t_cnt;
  logic [1:0]       t_idx;
  logic             t_emitted;

  // Burst register between the decision logic and the output register.
  logic             b_valid;
  logic [4:0][7:0]  b_bytes;
  logic [2:0]       b_cnt;
  logic [2:0]       b_pos;
  logic             b_tail;
  logic             b_has;

  logic [7:0] d_b0;
  logic [7:0] d_b1;
  logic [7:0] d_b2;
  dec_res_t   dec;
  logic       dec_has;
  logic       o_free;
  logic       b_last_pos;
  logic       b_free;
  logic       t_final;
  logic       t_need;
  logic       t_adv;
  logic       in_acc;
  logic       norm_dec;
  logic       b_move;

  always_comb begin
    if (tail_active) begin
      unique case (t_idx)
        2'd0: begin
          d_b0 = t_buf[0];
          d_b1 = t_buf[1];
          d_b2 = t_buf[2];
        end
        2'd1: begin
          d_b0 = t_buf[1];
          d_b1 = t_buf[2];
          d_b2 = 8'h00;
        end
        default: begin
          d_b0 = t_buf[2];
          d_b1 = 8'h00;
          d_b2 = 8'h00;
        end
      endcase
    end else begin
      d_b0 = win0;
      d_b1 = win1;
      d_b2 = in_byte;
    end
  end

  assign dec        = decide(ctx, d_b0, d_b1, d_b2);
  assign dec_has    = (dec.cnt != 3'd0);
  assign o_free     = !out_valid || !out_stall;
  assign b_last_pos = b_valid && (b_pos == b_cnt - 3'd1);
  assign b_free     = !b_valid || (b_last_pos && o_free);
  assign t_final    = (t_idx == t_cnt - 2'd1);
  // A final beat that yields no byte at all still returns an empty end marker.
  assign t_need     = dec_has || (t_final && !t_emitted);
  assign t_adv      = tail_active && (!t_need || b_free);
  assign in_stall   = tail_active || (b_valid && b_tail) || !b_free;
  assign in_acc     = in_valid && !in_stall;
  assign norm_dec   = in_acc && !in_last && (pend == 2'd2);
  // The last byte of a final-beat burst waits until it is known whether more follow.
  assign b_move     = b_valid && o_free &&
                      (!b_last_pos || !b_tail || !tail_active || dec_has);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 2'd0;
      win0        <= 8'h00;
      win1        <= 8'h00;
      ctx         <= CTX_RESET;
      tail_active <= 1'b0;
      t_emitted   <= 1'b0;
      b_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Input side.
      if (in_acc) begin
        if (in_last) begin
          t_buf[0]    <= (pend == 2'd0) ? in_byte : win0;
          t_buf[1]    <= (pend == 2'd0) ? 8'h00 : ((pend == 2'd1) ? in_byte : win1);
          t_buf[2]    <= (pend == 2'd2) ? in_byte : 8'h00;
          t_cnt       <= pend + 2'd1;
          t_idx       <= 2'd0;
          t_emitted   <= 1'b0;
          tail_active <= 1'b1;
          pend        <= 2'd0;
          win0        <= 8'h00;
          win1        <= 8'h00;
        end else if (pend == 2'd2) begin
          ctx  <= dec.st;
          win0 <= win1;
          win1 <= in_byte;
        end else begin
          if (pend == 2'd0) begin
            win0 <= in_byte;
          end else begin
            win1 <= in_byte;
          end
          pend <= pend + 2'd1;
        end
      end

      if (t_adv) begin
        t_idx     <= t_idx + 2'd1;
        t_emitted <= t_emitted || dec_has;
        if (t_final) begin
          tail_active <= 1'b0;
          ctx         <= CTX_RESET;
        end else begin
          ctx <= dec.st;
        end
      end

      // Burst register.
      if ((norm_dec && dec_has) || (t_adv && t_need)) begin
        b_valid <= 1'b1;
        b_pos   <= 3'd0;
        b_tail  <= tail_active;
        if (dec_has) begin
          b_bytes <= dec.bytes;
          b_cnt   <= dec.cnt;
          b_has   <= 1'b1;
        end else begin
          b_bytes <= '0;
          b_cnt   <= 3'd1;
          b_has   <= 1'b0;
        end
      end else if (b_move) begin
        if (b_last_pos) begin
          b_valid <= 1'b0;
        end else begin
          b_pos <= b_pos + 3'd1;
        end
      end

      // Output register.
      if (b_move) begin
        out_valid   <= 1'b1;
        out_byte    <= b_bytes[b_pos];
        has_byte    <= b_has;
        run_last    <= b_last_pos && (!b_tail || !tail_active);
        stream_done <= b_last_pos && b_tail && !tail_active;
      end else if (o_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LSM_ASSERT_IMP(a_done_is_run_last, out_valid && stream_done, run_last)
  `LSM_ASSERT_IMP(a_marker_is_final, out_valid && !has_byte, stream_done && run_last)
  `LSM_ASSERT_NXT(a_last_starts_tail, in_valid && !in_stall && in_last, tail_active)

endmodule
